// ===== src/rfrps_pkg.sv =====
// Package for the RC frame record/playback smoother.
// Holds channel limits, neutral values, buffer sizing, config indexes and stage codes.
// No dependencies.
`default_nettype none

package rfrps_pkg;

    localparam int BUFFER_FRAMES = 4096;
    localparam int CHAN_W        = 18;
    localparam int NCHAN         = 6;
    localparam int POS_W         = $clog2(BUFFER_FRAMES);
    localparam int FILL_W        = $clog2(BUFFER_FRAMES + 1);
    localparam int ROW_W         = NCHAN * CHAN_W;
    localparam int PROD_W        = CHAN_W + 9;
    localparam int CFG_IDX_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RECORD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PLAY   = 8'd1;

    localparam logic [7:0] ALPHA_RECORD_RST = 8'd64;
    localparam logic [7:0] ALPHA_PLAY_RST   = 8'd38;

    localparam logic [CHAN_W-1:0] LIM_LO [NCHAN] = '{
        CHAN_W'(65000), CHAN_W'(67000), CHAN_W'(60000),
        CHAN_W'(60000), CHAN_W'(60000), CHAN_W'(60000)
    };
    localparam logic [CHAN_W-1:0] LIM_HI [NCHAN] = '{
        CHAN_W'(166000), CHAN_W'(147000), CHAN_W'(160000),
        CHAN_W'(165000), CHAN_W'(165000), CHAN_W'(165000)
    };
    localparam logic [CHAN_W-1:0] NEUTRAL [NCHAN] = '{
        CHAN_W'((65000 + 166000) / 2), CHAN_W'((67000 + 147000) / 2),
        CHAN_W'((60000 + 160000) / 2), CHAN_W'((60000 + 165000) / 2),
        CHAN_W'((60000 + 165000) / 2), CHAN_W'((60000 + 165000) / 2)
    };

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_STORE,
        SRC_NEUTRAL
    } src_t;

    typedef enum logic [1:0] {
        FILT_NONE,
        FILT_REC,
        FILT_PLAY
    } filt_t;

    typedef logic [CHAN_W-1:0] chan_t;

endpackage

`default_nettype wire

// ===== src/rc_frame_record_playback_smoother.sv =====
// Top level of the RC frame record/playback smoother: frame ring buffer memory,
// position tracking, exponential smoothing with clamp, output register.
// Depends on rfrps_pkg.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------------
//  s_        | in        | s_valid / s_ready    | six 18-bit widths, five mode flags
//  m_        | out       | m_valid / m_ready    | six 18-bit widths
//  cfg_      | in        | cfg_valid / cfg_ready| cfg_index (8 b), cfg_data (8 b)
//
// One transaction per cycle while the output is not stalled.
// Stage 0 updates positions and writes or reads the frame memory; stage 1 takes
// the registered memory row, smooths and clamps; the output register holds the result.
// Written-entry tracking is a start mark and a fill count, so reset needs no clearing pass.
// A stalled output holds stage 1; s_ready stays high while stage 1 can drain or is empty.
`default_nettype none

module rc_frame_record_playback_smoother
    import rfrps_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [CHAN_W-1:0]    s_chan1_in,
    input  wire  [CHAN_W-1:0]    s_chan2_in,
    input  wire  [CHAN_W-1:0]    s_chan3_in,
    input  wire  [CHAN_W-1:0]    s_chan4_in,
    input  wire  [CHAN_W-1:0]    s_chan5_in,
    input  wire  [CHAN_W-1:0]    s_chan6_in,
    input  wire                  s_record_on,
    input  wire                  s_play_on,
    input  wire                  s_filter_on,
    input  wire                  s_step_forward,
    input  wire                  s_step_back,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [CHAN_W-1:0]    m_chan1_out,
    output logic [CHAN_W-1:0]    m_chan2_out,
    output logic [CHAN_W-1:0]    m_chan3_out,
    output logic [CHAN_W-1:0]    m_chan4_out,
    output logic [CHAN_W-1:0]    m_chan5_out,
    output logic [CHAN_W-1:0]    m_chan6_out,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [7:0]           cfg_data
);

    logic [7:0]        alpha_rec_reg;
    logic [7:0]        alpha_play_reg;
    logic              prev_rec_reg;
    logic [POS_W-1:0]  wr_pos_reg;
    logic [POS_W-1:0]  rd_pos_reg;
    logic [POS_W-1:0]  start_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ROW_W-1:0]  mem [BUFFER_FRAMES];
    logic [ROW_W-1:0]  rdata_reg;

    logic              st1_valid_reg;
    src_t              st1_src_reg;
    filt_t             st1_filt_reg;
    chan_t             st1_frame_reg [NCHAN];
    chan_t             hist_rec_reg  [NCHAN];
    chan_t             hist_play_reg [NCHAN];
    chan_t             out_reg       [NCHAN];
    logic              m_valid_reg;

    logic              s_fire;
    logic              advance;
    logic              st1_go;
    logic              rise;
    logic              do_rec;
    logic              do_play;
    logic              both_off;
    logic [POS_W-1:0]  start_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [POS_W-1:0]  rd_off;
    logic              hit;
    logic [POS_W-1:0]  wr_pos_inc;
    logic [POS_W-1:0]  rd_pos_inc;
    logic [POS_W-1:0]  rd_pos_dec;
    chan_t             in_frame [NCHAN];
    logic [ROW_W-1:0]  in_row;
    src_t              src_next;
    filt_t             filt_next;
    chan_t             sel_frame [NCHAN];
    chan_t             ema_frame [NCHAN];
    chan_t             res_frame [NCHAN];

    assign in_frame[0] = s_chan1_in;
    assign in_frame[1] = s_chan2_in;
    assign in_frame[2] = s_chan3_in;
    assign in_frame[3] = s_chan4_in;
    assign in_frame[4] = s_chan5_in;
    assign in_frame[5] = s_chan6_in;

    assign advance   = !m_valid_reg || m_ready;
    assign st1_go    = st1_valid_reg && advance;
    assign s_ready   = !st1_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Stage 0 control
    always_comb begin
        rise      = s_record_on && !prev_rec_reg;
        do_rec    = s_record_on && !s_play_on;
        do_play   = s_play_on && !s_record_on;
        both_off  = !s_record_on && !s_play_on;
        start_eff = rise ? wr_pos_reg : start_reg;
        fill_eff  = rise ? '0 : fill_reg;
        if (rd_pos_reg >= start_eff) begin
            rd_off = rd_pos_reg - start_eff;
        end else begin
            rd_off = rd_pos_reg + POS_W'(BUFFER_FRAMES) - start_eff;
        end
        hit = (fill_eff == FILL_W'(BUFFER_FRAMES)) || ({1'b0, rd_off} < fill_eff);
        wr_pos_inc = (wr_pos_reg == POS_W'(BUFFER_FRAMES - 1)) ? '0 : wr_pos_reg + 1'b1;
        rd_pos_inc = (rd_pos_reg == POS_W'(BUFFER_FRAMES - 1)) ? '0 : rd_pos_reg + 1'b1;
        rd_pos_dec = (rd_pos_reg == '0) ? '0 : rd_pos_reg - 1'b1;
        if (do_play) begin
            src_next = hit ? SRC_STORE : SRC_NEUTRAL;
        end else begin
            src_next = SRC_INPUT;
        end
        if (!s_filter_on) begin
            filt_next = FILT_NONE;
        end else if (s_record_on) begin
            filt_next = FILT_REC;
        end else if (s_play_on) begin
            filt_next = FILT_PLAY;
        end else begin
            filt_next = FILT_NONE;
        end
        for (int c = 0; c < NCHAN; c++) begin
            in_row[c*CHAN_W +: CHAN_W] = in_frame[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_rec_reg  <= ALPHA_RECORD_RST;
            alpha_play_reg <= ALPHA_PLAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ALPHA_RECORD: alpha_rec_reg  <= cfg_data;
                CFG_ALPHA_PLAY:   alpha_play_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_rec_reg <= 1'b0;
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            start_reg    <= '0;
            fill_reg     <= '0;
        end else if (s_fire) begin
            prev_rec_reg <= s_record_on;
            start_reg    <= start_eff;
            if (do_rec) begin
                wr_pos_reg <= wr_pos_inc;
                fill_reg   <= (fill_eff == FILL_W'(BUFFER_FRAMES)) ? fill_eff
                                                                 : fill_eff + 1'b1;
            end else begin
                fill_reg <= fill_eff;
            end
            if (do_play) begin
                if (s_step_forward) begin
                    rd_pos_reg <= rd_pos_inc;
                end else if (s_step_back) begin
                    rd_pos_reg <= rd_pos_dec;
                end
            end
            if (both_off) begin
                wr_pos_reg <= '0;
                rd_pos_reg <= '0;
            end
        end
    end

    // Frame memory: one row per frame
    always_ff @(posedge aclk) begin
        if (s_fire && do_rec) begin
            mem[wr_pos_reg] <= in_row;
        end
        if (s_fire) begin
            rdata_reg <= mem[rd_pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_src_reg  <= src_next;
            st1_filt_reg <= filt_next;
            for (int c = 0; c < NCHAN; c++) begin
                st1_frame_reg[c] <= in_frame[c];
            end
        end
    end

    // Stage 1: select, smooth, clamp
    always_comb begin
        logic [7:0]        a;
        logic [8:0]        a_inv;
        chan_t             h;
        logic [PROD_W-1:0] acc;
        logic [CHAN_W:0]   y;
        a     = (st1_filt_reg == FILT_REC) ? alpha_rec_reg : alpha_play_reg;
        a_inv = 9'd256 - {1'b0, a};
        for (int c = 0; c < NCHAN; c++) begin
            case (st1_src_reg)
                SRC_STORE:   sel_frame[c] = rdata_reg[c*CHAN_W +: CHAN_W];
                SRC_NEUTRAL: sel_frame[c] = NEUTRAL[c];
                default:     sel_frame[c] = st1_frame_reg[c];
            endcase
            h   = (st1_filt_reg == FILT_REC) ? hist_rec_reg[c] : hist_play_reg[c];
            acc = PROD_W'(a) * PROD_W'(sel_frame[c]) + PROD_W'(a_inv) * PROD_W'(h);
            y   = acc[PROD_W-1:8];
            if (y < {1'b0, LIM_LO[c]}) begin
                ema_frame[c] = LIM_LO[c];
            end else if (y > {1'b0, LIM_HI[c]}) begin
                ema_frame[c] = LIM_HI[c];
            end else begin
                ema_frame[c] = y[CHAN_W-1:0];
            end
            res_frame[c] = (st1_filt_reg == FILT_NONE) ? sel_frame[c] : ema_frame[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NCHAN; c++) begin
                hist_rec_reg[c]  <= '0;
                hist_play_reg[c] <= '0;
            end
        end else if (st1_go) begin
            for (int c = 0; c < NCHAN; c++) begin
                if (st1_filt_reg == FILT_REC) begin
                    hist_rec_reg[c] <= ema_frame[c];
                end
                if (st1_filt_reg == FILT_PLAY) begin
                    hist_play_reg[c] <= ema_frame[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_go) begin
            for (int c = 0; c < NCHAN; c++) begin
                out_reg[c] <= res_frame[c];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_chan1_out = out_reg[0];
    assign m_chan2_out = out_reg[1];
    assign m_chan3_out = out_reg[2];
    assign m_chan4_out = out_reg[3];
    assign m_chan5_out = out_reg[4];
    assign m_chan6_out = out_reg[5];

endmodule

`default_nettype wire

// ===== src/rfrps_checker.sv =====
// Port-level checker for rc_frame_record_playback_smoother, with its bind.
// Depends on rfrps_pkg.
`default_nettype none

module rfrps_checker
    import rfrps_pkg::*;
(
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire [CHAN_W-1:0]     m_chan1_out,
    input wire [CHAN_W-1:0]     m_chan6_out,
    input wire                  cfg_valid,
    input wire                  cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chan1_out) && $stable(m_chan6_out))
        else $error("output transaction dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind rc_frame_record_playback_smoother rfrps_checker u_rfrps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_chan1_out (m_chan1_out),
    .m_chan6_out (m_chan6_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);

`default_nettype wire

// ===== tb/tb_rc_frame_record_playback_smoother.sv =====
// Self-checking testbench for rc_frame_record_playback_smoother: random valid/ready
// traffic against a built-in frame recorder/player/smoother predictor.
// Depends on rfrps_pkg and the rc_frame_record_playback_smoother RTL.
module tb_rc_frame_record_playback_smoother;
    import rfrps_pkg::*;

    typedef logic [NCHAN-1:0][CHAN_W-1:0] frame_t;

    typedef struct packed {
        frame_t ch;
        logic   rec;
        logic   play;
        logic   filt;
        logic   fwd;
        logic   back;
    } frame_item_t;

    typedef enum int {PAT_ZERO, PAT_ONES, PAT_FULL, PAT_RANGE, PAT_MIX} pattern_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CHAN_W-1:0]    s_chan1_in = '0;
    logic [CHAN_W-1:0]    s_chan2_in = '0;
    logic [CHAN_W-1:0]    s_chan3_in = '0;
    logic [CHAN_W-1:0]    s_chan4_in = '0;
    logic [CHAN_W-1:0]    s_chan5_in = '0;
    logic [CHAN_W-1:0]    s_chan6_in = '0;
    logic                 s_record_on = 1'b0;
    logic                 s_play_on = 1'b0;
    logic                 s_filter_on = 1'b0;
    logic                 s_step_forward = 1'b0;
    logic                 s_step_back = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CHAN_W-1:0]    m_chan1_out;
    logic [CHAN_W-1:0]    m_chan2_out;
    logic [CHAN_W-1:0]    m_chan3_out;
    logic [CHAN_W-1:0]    m_chan4_out;
    logic [CHAN_W-1:0]    m_chan5_out;
    logic [CHAN_W-1:0]    m_chan6_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    rc_frame_record_playback_smoother dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_chan1_in     (s_chan1_in),
        .s_chan2_in     (s_chan2_in),
        .s_chan3_in     (s_chan3_in),
        .s_chan4_in     (s_chan4_in),
        .s_chan5_in     (s_chan5_in),
        .s_chan6_in     (s_chan6_in),
        .s_record_on    (s_record_on),
        .s_play_on      (s_play_on),
        .s_filter_on    (s_filter_on),
        .s_step_forward (s_step_forward),
        .s_step_back    (s_step_back),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chan1_out    (m_chan1_out),
        .m_chan2_out    (m_chan2_out),
        .m_chan3_out    (m_chan3_out),
        .m_chan4_out    (m_chan4_out),
        .m_chan5_out    (m_chan5_out),
        .m_chan6_out    (m_chan6_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predictor state
    frame_t             frame_mem [BUFFER_FRAMES];
    bit                 written_map [BUFFER_FRAMES];
    logic [POS_W-1:0]   wr_pos = '0;
    logic [POS_W-1:0]   rd_pos = '0;
    frame_t             hist_rec = '0;
    frame_t             hist_play = '0;
    bit                 rec_prev = 1'b0;
    logic [7:0]         alpha_rec = 8'd64;
    logic [7:0]         alpha_play = 8'd38;

    frame_item_t frames_to_send [$];
    frame_t      predicted_out [$];
    frame_item_t offer;
    int          gap_cnt = 0;
    int          hold_cnt = 0;
    bit          long_hold = 1'b0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          n_queued = 0;
    int          n_results = 0;
    int          n_err = 0;

    function automatic int lim_lo_of(int c);
        case (c)
            0: return 65000;
            1: return 67000;
            default: return 60000;
        endcase
    endfunction

    function automatic int lim_hi_of(int c);
        case (c)
            0: return 166000;
            1: return 147000;
            2: return 160000;
            default: return 165000;
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] ema_clamp(int c, logic [CHAN_W-1:0] x,
                                                  logic [CHAN_W-1:0] prev, logic [7:0] a);
        longint acc;
        acc = (longint'(a) * longint'(x) + longint'(256 - int'(a)) * longint'(prev)) >> 8;
        if (acc < lim_lo_of(c)) acc = lim_lo_of(c);
        if (acc > lim_hi_of(c)) acc = lim_hi_of(c);
        return acc[CHAN_W-1:0];
    endfunction

    function automatic frame_t predict_output_frame(frame_item_t it);
        frame_t f;
        f = it.ch;
        if (it.rec && !rec_prev) begin
            for (int i = 0; i < BUFFER_FRAMES; i++) written_map[i] = 1'b0;
        end
        rec_prev = it.rec;
        if (it.rec && !it.play) begin
            frame_mem[wr_pos] = f;
            written_map[wr_pos] = 1'b1;
            wr_pos = wr_pos + 1'b1;
        end else if (it.play && !it.rec) begin
            for (int c = 0; c < NCHAN; c++) begin
                f[c] = written_map[rd_pos] ? frame_mem[rd_pos][c]
                                           : CHAN_W'((lim_lo_of(c) + lim_hi_of(c)) / 2);
            end
            if (it.fwd) rd_pos = rd_pos + 1'b1;
            else if (it.back && rd_pos != 0) rd_pos = rd_pos - 1'b1;
        end else if (!it.rec && !it.play) begin
            wr_pos = '0;
            rd_pos = '0;
        end
        if (it.filt && it.rec) begin
            for (int c = 0; c < NCHAN; c++) begin
                f[c] = ema_clamp(c, f[c], hist_rec[c], alpha_rec);
                hist_rec[c] = f[c];
            end
        end else if (it.filt && it.play) begin
            for (int c = 0; c < NCHAN; c++) begin
                f[c] = ema_clamp(c, f[c], hist_play[c], alpha_play);
                hist_play[c] = f[c];
            end
        end
        return f;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan(pattern_t pat);
        int r;
        r = $urandom_range(99);
        case (pat)
            PAT_ZERO: return '0;
            PAT_ONES: return '1;
            PAT_FULL: return CHAN_W'($urandom);
            PAT_RANGE: return CHAN_W'($urandom_range(40000, 190000));
            default: begin
                if (r < 5) return '0;
                if (r < 10) return '1;
                if (r < 40) return CHAN_W'($urandom);
                return CHAN_W'($urandom_range(40000, 190000));
            end
        endcase
    endfunction

    task automatic queue_frame(bit rec, bit play, bit filt, bit fwd, bit back, pattern_t pat);
        frame_item_t it;
        for (int c = 0; c < NCHAN; c++) it.ch[c] = pick_chan(pat);
        it.rec = rec;
        it.play = play;
        it.filt = filt;
        it.fwd = fwd;
        it.back = back;
        frames_to_send.push_back(it);
        n_queued++;
    endtask

    function automatic bit coin(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Mostly record-then-play sessions with random content, some noise
    task automatic queue_session();
        int  r;
        int  n;
        bit  filt;
        r = $urandom_range(99);
        if (r < 70) begin
            if (coin(30)) queue_frame(0, 0, coin(50), coin(50), coin(50), PAT_MIX);
            n = $urandom_range(2, 24);
            filt = coin(50);
            repeat (n) queue_frame(1, 0, coin(90) ? filt : !filt, coin(20), coin(20), PAT_MIX);
            n = $urandom_range(2, 30);
            filt = coin(50);
            repeat (n) queue_frame(0, 1, coin(90) ? filt : !filt, coin(65), coin(50), PAT_MIX);
        end else if (r < 85) begin
            n = $urandom_range(1, 8);
            repeat (n) queue_frame(coin(50), coin(50), coin(50), coin(50), coin(50), PAT_MIX);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) queue_frame(1, 1, coin(50), coin(50), coin(50), PAT_MIX);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ALPHA_RECORD) alpha_rec = val;
        else if (idx == CFG_ALPHA_PLAY) alpha_play = val;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (frames_to_send.size() != 0 || s_valid || predicted_out.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("rc_frame_record_playback_smoother: mismatch");
        $finish;
    end

    // hold off the receiver long enough to back up the pipeline
    initial begin
        wait (n_results >= 50);
        @(negedge aclk);
        long_hold = 1'b1;
        repeat (90) @(negedge aclk);
        long_hold = 1'b0;
        wait (n_results >= 320);
        @(negedge aclk);
        long_hold = 1'b1;
        repeat (90) @(negedge aclk);
        long_hold = 1'b0;
    end

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predicted_out.push_back(predict_output_frame(offer));
            if (!s_valid || s_ready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_valid <= 1'b0;
                end else if (frames_to_send.size() != 0) begin
                    offer = frames_to_send.pop_front();
                    s_valid        <= 1'b1;
                    s_chan1_in     <= offer.ch[0];
                    s_chan2_in     <= offer.ch[1];
                    s_chan3_in     <= offer.ch[2];
                    s_chan4_in     <= offer.ch[3];
                    s_chan5_in     <= offer.ch[4];
                    s_chan6_in     <= offer.ch[5];
                    s_record_on    <= offer.rec;
                    s_play_on      <= offer.play;
                    s_filter_on    <= offer.filt;
                    s_step_forward <= offer.fwd;
                    s_step_back    <= offer.back;
                    if (coin(src_idle_pct)) gap_cnt = $urandom_range(1, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        frame_t got;
        frame_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_chan6_out, m_chan5_out, m_chan4_out,
                       m_chan3_out, m_chan2_out, m_chan1_out};
                if (predicted_out.size() == 0) begin
                    if (n_err < 10) $display("unexpected output frame %h", got);
                    n_err++;
                end else begin
                    want = predicted_out.pop_front();
                    for (int c = 0; c < NCHAN; c++) begin
                        if (got[c] !== want[c]) begin
                            if (n_err < 10)
                                $display("frame %0d chan%0d: expected %0d, got %0d",
                                         n_results, c + 1, want[c], got[c]);
                            n_err++;
                        end
                    end
                end
                n_results++;
            end
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (coin(sink_idle_pct)) begin
                hold_cnt = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct = 30;
        sink_idle_pct = 30;
        queue_frame(0, 0, 0, 0, 0, PAT_ZERO);
        queue_frame(0, 0, 1, 1, 1, PAT_ONES);
        queue_frame(0, 1, 0, 1, 0, PAT_FULL);
        queue_frame(0, 1, 0, 1, 1, PAT_FULL);
        queue_frame(0, 1, 1, 0, 1, PAT_FULL);
        queue_frame(0, 1, 0, 0, 1, PAT_MIX);
        queue_frame(0, 1, 0, 0, 1, PAT_MIX);
        queue_frame(1, 0, 0, 1, 1, PAT_ONES);
        queue_frame(1, 0, 1, 0, 0, PAT_ZERO);
        queue_frame(1, 0, 1, 0, 0, PAT_ONES);
        queue_frame(1, 0, 0, 0, 0, PAT_FULL);
        queue_frame(1, 1, 1, 1, 1, PAT_RANGE);
        queue_frame(1, 1, 0, 0, 0, PAT_ONES);
        queue_frame(0, 1, 1, 0, 0, PAT_RANGE);
        queue_frame(0, 1, 0, 1, 0, PAT_RANGE);
        queue_frame(0, 1, 0, 1, 0, PAT_RANGE);
        queue_frame(0, 1, 0, 1, 0, PAT_RANGE);
        queue_frame(0, 1, 1, 1, 0, PAT_RANGE);
        queue_frame(0, 1, 0, 0, 0, PAT_RANGE);
        queue_frame(1, 0, 0, 0, 0, PAT_FULL);
        queue_frame(0, 1, 0, 0, 1, PAT_RANGE);
        queue_frame(0, 1, 0, 0, 1, PAT_RANGE);
        queue_frame(0, 0, 0, 0, 0, PAT_ONES);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            repeat (4) @(negedge aclk);
            case (ph)
                0: begin write_reg(CFG_ALPHA_RECORD, 8'd0);   write_reg(CFG_ALPHA_PLAY, 8'd255); end
                1: begin write_reg(CFG_ALPHA_RECORD, 8'd255); write_reg(CFG_ALPHA_PLAY, 8'd0);   end
                2: begin write_reg(CFG_ALPHA_RECORD, 8'd128); write_reg(CFG_ALPHA_PLAY, 8'd1);   end
                3: begin
                    write_reg(CFG_ALPHA_RECORD, 8'($urandom));
                    write_reg(CFG_ALPHA_PLAY, 8'($urandom));
                end
                default: begin
                    write_reg(CFG_ALPHA_RECORD, 8'd64);
                    write_reg(CFG_ALPHA_PLAY, 8'd38);
                end
            endcase
            @(negedge aclk);
            src_idle_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
            sink_idle_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
            start = n_queued;
            while (n_queued - start < 70) queue_session();
            wait_drained();
        end

        // closing stretch, no idling
        repeat (4) @(negedge aclk);
        write_reg(CFG_ALPHA_RECORD, 8'($urandom));
        write_reg(CFG_ALPHA_PLAY, 8'($urandom));
        @(negedge aclk);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        start = n_queued;
        while (n_queued - start < 30) queue_session();
        wait_drained();

        repeat (20) @(posedge aclk);
        if (n_err == 0 && predicted_out.size() == 0) begin
            $display("rc_frame_record_playback_smoother: match");
        end else begin
            $display("rc_frame_record_playback_smoother: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/rfrps_pkg.sv
src/rc_frame_record_playback_smoother.sv
src/rfrps_checker.sv
tb/tb_rc_frame_record_playback_smoother.sv
